[hw/rtl/bds_pkg.sv]
// Shared types, constants and the natural-log table of the BM25 document scorer.
// No dependencies; the top, sequencer, datapath and testbench import this package.
package bds_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_DEPTH = 256;
  localparam int LN_W      = 16;
  localparam int DIV_STEPS = 25;
  localparam int DIV_INT   = 9;

  // configuration register indexes
  localparam logic [7:0] CFG_DOC_COUNT      = 8'd0;
  localparam logic [7:0] CFG_AVG_DOC_LENGTH = 8'd1;

  localparam logic signed [41:0] SCORE_MAX = 42'sd549755813887;
  localparam logic signed [41:0] SCORE_MIN = -42'sd549755813888;

  typedef logic [LN_W-1:0] ln_tbl_t [LOG_DEPTH+1];

  // floor(num / den) by shift and subtract, used only while building the table
  function automatic longint unsigned const_quot(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/depth) = 2*atanh(i/(2*depth+i)), series in Q30, rounded to FRAC_BITS
  function automatic ln_tbl_t build_ln_tbl();
    ln_tbl_t tbl;
    longint unsigned z, z2, t, s;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      z  = const_quot(64'(i) << 30, 64'(2 * LOG_DEPTH + i));
      z2 = (z * z) >> 30;
      t  = z;
      s  = 0;
      for (int k = 1; k < 80; k += 2) begin
        if (t != 0) begin
          s = s + const_quot(t, 64'(k));
          t = (t * z2) >> 30;
        end
      end
      s = s * 2;
      tbl[i] = LN_W'((s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
    return tbl;
  endfunction

  localparam ln_tbl_t LN_TBL = build_ln_tbl();

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_TF_INIT,
    OP_DIV_STEP,
    OP_TF_END,
    OP_Q_INIT,
    OP_Q_END,
    OP_LN_INIT,
    OP_NORM,
    OP_LN_FETCH,
    OP_LN_MUL,
    OP_LN_END,
    OP_TQ,
    OP_TERM,
    OP_ACC
  } bds_op_e;

  typedef struct packed {
    bds_op_e op;
    logic    div_int;
    logic    ln_sel;
  } bds_cmd_t;

  typedef struct packed {
    logic norm_done;
    logic last;
    logic out_full;
  } bds_stat_t;

endpackage

[hw/rtl/bds_if.sv]
// Channel interfaces of the BM25 document scorer: term input, score output,
// configuration write. Depends on nothing.
interface bds_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] doc_freq;
  logic [15:0] term_count;
  logic [15:0] query_term_count;
  logic [23:0] doc_length;
  logic        last_term;
  modport source (output valid, doc_freq, term_count, query_term_count, doc_length,
                  last_term, input ready);
  modport sink (input valid, doc_freq, term_count, query_term_count, doc_length,
                last_term, output ready);
endinterface

interface bds_out_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] score;
  logic               score_nonzero;
  modport source (output valid, score, score_nonzero, input ready);
  modport sink (input valid, score, score_nonzero, output ready);
endinterface

interface bds_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bm25_document_scorer_top.sv]
// Okapi BM25 document scorer, top level: joins sequencer and datapath to
// the channel interfaces. Depends on bds_pkg, bds_if, bds_ctrl, bds_datapath.
//
// One query term per input transaction; the score (Q.16, saturated to 40
// bits) comes out on the transaction marked last_term, then the sum restarts.
// Between acceptance of a term and the next ready lie two 25-step
// restoring divisions (TF and QTF factors) on one shared divider, two
// logarithms whose argument is normalized one bit per cycle, and a few
// multiply and accumulate steps. A last term waits further while the
// previous score is still held on the output.
// Configuration writes are taken every cycle.
module bm25_document_scorer_top import bds_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  bds_in_if.sink    in_if,
  bds_out_if.source out_if,
  bds_cfg_if.sink   cfg_if
);

  bds_cmd_t  cmd;
  bds_stat_t stat;

  assign cfg_if.ready = 1'b1;

  bds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bds_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .cfg_we_i           (cfg_if.valid),
    .cfg_index_i        (cfg_if.index),
    .cfg_data_i         (cfg_if.data),
    .doc_freq_i         (in_if.doc_freq),
    .term_count_i       (in_if.term_count),
    .query_term_count_i (in_if.query_term_count),
    .doc_length_i       (in_if.doc_length),
    .last_term_i        (in_if.last_term),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .score_o            (out_if.score),
    .score_nonzero_o    (out_if.score_nonzero)
  );

endmodule

[hw/rtl/bds_ctrl.sv]
// Sequencer of the BM25 scorer: walks one term through divide, log and
// accumulate steps. Depends on bds_pkg.
module bds_ctrl import bds_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bds_stat_t stat_i,
  output bds_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_TF_INIT, S_TF_DIV, S_TF_END, S_Q_INIT, S_Q_DIV, S_Q_END,
    S_LN_INIT, S_LN_NORM, S_LN_FETCH, S_LN_MUL, S_LN_END, S_TQ, S_TERM, S_ACC
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic       sel_q;
  logic       acc_hold;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc_hold   = stat_i.last && stat_i.out_full;

  // decode the command for the current step; the last integer step already
  // moves the remainder into fraction alignment
  always_comb begin
    cmd_o.div_int = (cnt_q < 5'(DIV_INT - 1));
    cmd_o.ln_sel  = sel_q;
    case (state_q)
      S_IDLE:     cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_MUL:      cmd_o.op = OP_MUL;
      S_TF_INIT:  cmd_o.op = OP_TF_INIT;
      S_TF_DIV:   cmd_o.op = OP_DIV_STEP;
      S_TF_END:   cmd_o.op = OP_TF_END;
      S_Q_INIT:   cmd_o.op = OP_Q_INIT;
      S_Q_DIV:    cmd_o.op = OP_DIV_STEP;
      S_Q_END:    cmd_o.op = OP_Q_END;
      S_LN_INIT:  cmd_o.op = OP_LN_INIT;
      S_LN_NORM:  cmd_o.op = OP_NORM;
      S_LN_FETCH: cmd_o.op = OP_LN_FETCH;
      S_LN_MUL:   cmd_o.op = OP_LN_MUL;
      S_LN_END:   cmd_o.op = OP_LN_END;
      S_TQ:       cmd_o.op = OP_TQ;
      S_TERM:     cmd_o.op = OP_TERM;
      S_ACC:      cmd_o.op = acc_hold ? OP_NONE : OP_ACC;
      default:    cmd_o.op = OP_NONE;
    endcase
  end

  // advance the step sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:    if (in_valid_i) state_q <= S_MUL;
        S_MUL:     state_q <= S_TF_INIT;
        S_TF_INIT: begin
          cnt_q   <= '0;
          state_q <= S_TF_DIV;
        end
        S_TF_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DIV_STEPS - 1)) state_q <= S_TF_END;
        end
        S_TF_END:  state_q <= S_Q_INIT;
        S_Q_INIT: begin
          cnt_q   <= '0;
          state_q <= S_Q_DIV;
        end
        S_Q_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(DIV_STEPS - 1)) state_q <= S_Q_END;
        end
        S_Q_END: begin
          sel_q   <= 1'b0;
          state_q <= S_LN_INIT;
        end
        S_LN_INIT:  state_q <= S_LN_NORM;
        S_LN_NORM:  if (stat_i.norm_done) state_q <= S_LN_FETCH;
        S_LN_FETCH: state_q <= S_LN_MUL;
        S_LN_MUL:   state_q <= S_LN_END;
        S_LN_END: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= S_LN_INIT;
          end else begin
            state_q <= S_TQ;
          end
        end
        S_TQ:   state_q <= S_TERM;
        S_TERM: state_q <= S_ACC;
        S_ACC:  if (!acc_hold) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  property p_div_len;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_TF_DIV || state_q == S_Q_DIV) |-> cnt_q < 5'(DIV_STEPS);
  endproperty
  a_div_len: assert property (p_div_len) else $error("divide step count overrun");

  property p_ln_order;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_TQ) |-> sel_q;
  endproperty
  a_ln_order: assert property (p_ln_order) else $error("idf taken before both logs");

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_ACC && acc_hold) |=> state_q == S_ACC;
  endproperty
  a_hold: assert property (p_hold) else $error("score dropped while output full");

endmodule

[hw/rtl/bds_datapath.sv]
// Datapath of the BM25 scorer: configuration registers, shared restoring
// divider, log normalizer with table interpolation, accumulator. Uses bds_pkg.
module bds_datapath import bds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bds_cmd_t           cmd_i,
  output bds_stat_t          stat_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [23:0]        doc_freq_i,
  input  logic [15:0]        term_count_i,
  input  logic [15:0]        query_term_count_i,
  input  logic [23:0]        doc_length_i,
  input  logic               last_term_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [39:0] score_o,
  output logic               score_nonzero_o
);

  logic [23:0] doc_count_q;
  logic [31:0] avg_q;
  logic [23:0] df_q, dl_q;
  logic [15:0] tf_q, qtf_q;
  logic        last_q;
  logic [47:0] prod_q;
  logic [36:0] base_q;
  logic [53:0] r_q;
  logic [60:0] d_q;
  logic [24:0] quo_q;
  logic        den_zero_q;
  logic [17:0] tf_frac_q;
  logic [24:0] qtf_frac_q;
  logic [24:0] xn_q;
  logic [4:0]  e_q;
  logic [LN_W-1:0] t0_q, diff_q, lo_q;
  logic [20:0] ln_base_q;
  logic [15:0] interp_q;
  logic [20:0] ln_num_q, ln_den_q;
  logic        idf_neg_q;
  logic [20:0] idf_mag_q;
  logic [26:0] tq_q;
  logic [31:0] term_q;
  logic signed [39:0] acc_q;
  logic signed [39:0] score_q;
  logic        out_valid_q;

  logic [51:0] den_tf;
  logic [52:0] num_tf;
  logic        ge;
  logic [53:0] r_sub;
  logic [7:0]  idx;
  logic [LN_W-1:0] t0, t1;
  logic [42:0] tq_full;
  logic [47:0] term_full;
  logic signed [41:0] sum, sum_sat;

  assign den_tf = {1'b0, prod_q, 3'b000} + 52'(base_q);
  assign num_tf = {1'b0, prod_q, 4'b0000} + {3'b000, prod_q, 2'b00};
  assign ge     = {7'd0, r_q} >= d_q;
  assign r_sub  = ge ? r_q - d_q[53:0] : r_q;
  assign idx    = xn_q[23:16];
  assign t0     = LN_TBL[{1'b0, idx}];
  assign t1     = LN_TBL[{1'b0, idx} + 9'd1];
  assign tq_full   = {25'd0, tf_frac_q} * {18'd0, qtf_frac_q};
  assign term_full = {27'd0, idf_mag_q} * {21'd0, tq_q};
  assign sum = 42'(acc_q) + (idf_neg_q ? -$signed({10'd0, term_q}) : $signed({10'd0, term_q}));

  always_comb begin
    sum_sat = sum;
    if (sum > SCORE_MAX) sum_sat = SCORE_MAX;
    if (sum < SCORE_MIN) sum_sat = SCORE_MIN;
  end

  assign stat_o.norm_done = xn_q[24];
  assign stat_o.last      = last_q;
  assign stat_o.out_full  = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign score_o         = score_q;
  assign score_nonzero_o = (score_q != '0);

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      doc_count_q <= 24'd1;
      avg_q       <= 32'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DOC_COUNT:      doc_count_q <= cfg_data_i[23:0];
        CFG_AVG_DOC_LENGTH: avg_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // accumulate terms, emit on the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.op == OP_ACC) begin
        if (last_q) begin
          acc_q       <= '0;
          out_valid_q <= 1'b1;
        end else begin
          acc_q <= 40'(sum_sat);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACC && last_q) score_q <= 40'(sum_sat);
  end

  // per-term arithmetic steps
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        df_q   <= (doc_freq_i > doc_count_q) ? doc_count_q : doc_freq_i;
        tf_q   <= term_count_i;
        qtf_q  <= query_term_count_i;
        dl_q   <= doc_length_i;
        last_q <= last_term_i;
      end
      OP_MUL: begin
        prod_q <= {32'd0, tf_q} * {16'd0, avg_q};
        base_q <= {3'b000, avg_q, 1'b0} + {5'd0, avg_q} + {2'b00, dl_q, 11'd0}
                  + {5'd0, dl_q, 8'd0};
      end
      OP_TF_INIT: begin
        den_zero_q <= (den_tf == '0);
        d_q        <= {1'b0, den_tf, 8'd0};
        r_q        <= {1'b0, num_tf};
        quo_q      <= '0;
      end
      OP_Q_INIT: begin
        d_q   <= 61'({1'b0, qtf_q} + 17'd500) << 8;
        r_q   <= 54'({9'd0, qtf_q} * 25'd501);
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        quo_q <= {quo_q[23:0], ge};
        if (cmd_i.div_int) begin
          r_q <= r_sub;
          d_q <= d_q >> 1;
        end else begin
          r_q <= {r_sub[52:0], 1'b0};
        end
      end
      OP_TF_END: tf_frac_q <= den_zero_q ? '0 : quo_q[17:0];
      OP_Q_END:  qtf_frac_q <= quo_q;
      OP_LN_INIT: begin
        xn_q <= cmd_i.ln_sel ? {df_q, 1'b1} : {doc_count_q - df_q, 1'b1};
        e_q  <= 5'd24;
      end
      OP_NORM: begin
        if (!xn_q[24]) begin
          xn_q <= {xn_q[23:0], 1'b0};
          e_q  <= e_q - 5'd1;
        end
      end
      OP_LN_FETCH: begin
        t0_q   <= t0;
        diff_q <= t1 - t0;
        lo_q   <= xn_q[15:0];
      end
      OP_LN_MUL: begin
        ln_base_q <= 21'({16'd0, e_q} * {5'd0, LN_TBL[LOG_DEPTH]}) + 21'(t0_q);
        interp_q  <= 16'(({16'd0, diff_q} * {16'd0, lo_q}) >> 16);
      end
      OP_LN_END: begin
        if (cmd_i.ln_sel) ln_den_q <= ln_base_q + 21'(interp_q);
        else              ln_num_q <= ln_base_q + 21'(interp_q);
      end
      OP_TQ: begin
        idf_neg_q <= ln_den_q > ln_num_q;
        idf_mag_q <= (ln_den_q > ln_num_q) ? ln_den_q - ln_num_q : ln_num_q - ln_den_q;
        tq_q      <= tq_full[42:16];
      end
      OP_TERM: term_q <= term_full[47:16];
      default: ;
    endcase
  end

  property p_acc_clear;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.op == OP_ACC && last_q) |=> acc_q == '0;
  endproperty
  a_acc_clear: assert property (p_acc_clear) else $error("accumulator not cleared");

  property p_norm;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.op == OP_LN_FETCH) |-> xn_q[24];
  endproperty
  a_norm: assert property (p_norm) else $error("log argument not normalized");

  property p_tf_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.op == OP_TQ) |-> tf_frac_q <= 18'd163840;
  endproperty
  a_tf_bound: assert property (p_tf_bound) else $error("tf factor out of range");

endmodule

[tb/sv/bds_tb_if.sv]
// Transaction types of the BM25 scorer testbench: stimulus row and expected
// score. Depends on nothing; the channel interfaces come from the design.
`timescale 1ns / 1ps
package bds_tb_pkg;

  typedef struct {
    logic [23:0] df;
    logic [15:0] tf;
    logic [15:0] qtf;
    logic [23:0] dl;
    logic        last;
    logic        known;
    logic [39:0] score;
  } term_row_t;

  typedef struct {
    logic [39:0] score;
    logic        nonzero;
  } score_t;

endpackage

[tb/sv/testbench.sv]
// Testbench of the BM25 document scorer: directed term table, then random
// documents, each score checked against a scoring model. Depends on bds_pkg, bds_tb_pkg, bds_if and the top.
`timescale 1ns / 1ps
module testbench;
  import bds_pkg::*;
  import bds_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] AVG_SET [4] = '{32'd1, 32'd256, 32'd25600, 32'hFFFF_FFFF};
  localparam logic [23:0] N_SET [4] = '{24'd1, 24'd1000, 24'd100000, 24'hFFFFFF};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bds_in_if  in_if ();
  bds_out_if out_if ();
  bds_cfg_if cfg_if ();

  bm25_document_scorer_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // scorer state
  longint unsigned   ln_entry [LOG_DEPTH+1];
  longint unsigned   n_docs = 1;
  longint unsigned   avg_len = 256;
  longint            score_sum = 0;
  score_t            score_q [$];
  int                fail_cnt = 0;
  int                idle_cycles = 0;
  bit                timed_out = 0;

  function automatic void fill_ln_entries();
    longint unsigned z, z2, t, s;
    for (int i = 0; i <= LOG_DEPTH; i++) begin
      z  = (longint'(i) << 30) / longint'(2 * LOG_DEPTH + i);
      z2 = (z * z) >> 30;
      t  = z;
      s  = 0;
      for (int k = 1; k < 80 && t != 0; k += 2) begin
        s += t / longint'(k);
        t = (t * z2) >> 30;
      end
      s *= 2;
      ln_entry[i] = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    end
  endfunction

  function automatic longint unsigned ln_fixed(longint unsigned x);
    int unsigned     e;
    longint unsigned m, pos, idx, rem, diff;
    e = 0;
    while (e < 62 && (x >> (e + 1)) != 0) e++;
    m = x - (64'd1 << e);
    pos = m * LOG_DEPTH;
    idx = pos >> e;
    if (idx >= LOG_DEPTH) idx = LOG_DEPTH - 1;
    rem = pos - (idx << e);
    diff = ln_entry[idx + 1] - ln_entry[idx];
    return longint'(e) * ln_entry[LOG_DEPTH] + ln_entry[idx] + ((diff * rem) >> e);
  endfunction

  // floor(num * 2^F / den) by long division, avoids 64-bit overflow
  function automatic longint unsigned fix_div(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    for (int k = 0; k < FRAC_BITS; k++) begin
      q = q << 1;
      r = r << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // add one term to the running score; queue a score on the last term
  function automatic void score_term(term_row_t row);
    longint unsigned df, lnum, lden, mag, tfq, qq, tden, tq, tmag;
    bit              neg;
    longint          sum;
    score_t          res;
    df = row.df;
    if (df > n_docs) df = n_docs;
    lnum = ln_fixed(2 * n_docs - 2 * df + 1);
    lden = ln_fixed(2 * df + 1);
    neg = lden > lnum;
    mag = neg ? lden - lnum : lnum - lden;
    tden = 3 * avg_len + 2304 * longint'(row.dl) + 8 * longint'(row.tf) * avg_len;
    tfq = (tden == 0) ? 0 : fix_div(20 * longint'(row.tf) * avg_len, tden);
    qq = fix_div(501 * longint'(row.qtf), 500 + longint'(row.qtf));
    tq = (tfq * qq) >> FRAC_BITS;
    tmag = (mag * tq) >> FRAC_BITS;
    sum = score_sum + (neg ? -longint'(tmag) : longint'(tmag));
    if (sum > longint'(SCORE_MAX)) sum = SCORE_MAX;
    if (sum < longint'(SCORE_MIN)) sum = SCORE_MIN;
    score_sum = sum;
    if (row.last) begin
      res.score = sum[39:0];
      res.nonzero = (sum != 0);
      score_q = {score_q, res};
      score_sum = 0;
    end
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // send one term transaction, hold until accepted; valid stays up afterwards
  // unless a gap follows
  task automatic send_term(term_row_t row);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.doc_freq         <= row.df;
    in_if.term_count       <= row.tf;
    in_if.query_term_count <= row.qtf;
    in_if.doc_length       <= row.dl;
    in_if.last_term        <= row.last;
    do @(posedge clk_i); while (!in_if.ready);
    score_term(row);
    if (row.known && row.last && score_q[$].score != row.score) begin
      $error("score table entry: expected %0d, predicted %0d",
             $signed(row.score), $signed(score_q[$].score));
      fail_cnt++;
    end
  endtask

  // write one register while the block is idle
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_DOC_COUNT) n_docs = val[23:0];
    else if (idx == CFG_AVG_DOC_LENGTH) avg_len = val;
  endtask

  // drop valid and wait for every expected score
  task automatic wait_scores();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (score_q.size() != 0);
  endtask

  task automatic drain();
    wait_scores();
    repeat (150) @(posedge clk_i);
  endtask

  function automatic term_row_t mk(logic [23:0] df, logic [15:0] tf, logic [15:0] qtf,
                                   logic [23:0] dl, logic last);
    term_row_t r;
    r.df = df; r.tf = tf; r.qtf = qtf; r.dl = dl; r.last = last;
    r.known = 1'b0; r.score = '0;
    return r;
  endfunction

  function automatic term_row_t rand_term(logic last);
    term_row_t r;
    int        p;
    p = $urandom_range(0, 9);
    r = mk(0, 0, 0, 0, last);
    r.df  = (p == 0) ? 24'($urandom) : 24'($urandom_range(0, 32'(n_docs)));
    r.tf  = (p < 3) ? 16'($urandom) : 16'($urandom_range(0, 20));
    r.qtf = (p == 1) ? 16'($urandom) : 16'($urandom_range(0, 4));
    r.dl  = (p == 2) ? 24'($urandom) : 24'($urandom_range(0, 2000));
    return r;
  endfunction

  // score checker and output stall
  always @(posedge clk_i) begin
    score_t exp_s;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (score_q.size() == 0) begin
        $error("score: unexpected transaction, actual %0d", out_if.score);
        fail_cnt++;
      end else begin
        exp_s = score_q.pop_front();
        if (out_if.score !== exp_s.score) begin
          $error("score: expected %0d, actual %0d", $signed(exp_s.score), out_if.score);
          fail_cnt++;
        end
        if (out_if.score_nonzero !== exp_s.nonzero) begin
          $error("score_nonzero: expected %0d, actual %0d", exp_s.nonzero,
                 out_if.score_nonzero);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int stall;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        stall = gap_len();
        out_if.ready <= (stall == 0);
      end
    end
  end

  // watchdog on accepted transactions
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !in_if.valid && score_q.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    term_row_t dir_tab [$];
    term_row_t row;
    int        n_terms;
    int        phase;

    in_if.valid = 1'b0;
    in_if.doc_freq = '0;
    in_if.term_count = '0;
    in_if.query_term_count = '0;
    in_if.doc_length = '0;
    in_if.last_term = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_DOC_COUNT;
    cfg_if.data = '0;
    fill_ln_entries();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset N = 1: zero query count scores zero; extreme fields go
    // through the predictor
    row = mk(0, 5, 0, 10, 1'b1); row.known = 1; row.score = 0; dir_tab = {dir_tab, row};
    row = mk(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
    dir_tab = {dir_tab, row};
    foreach (dir_tab[i]) send_term(dir_tab[i]);
    drain();
    dir_tab.delete();

    // zero document count and zero average length
    write_reg(CFG_DOC_COUNT, 32'd0);
    write_reg(CFG_AVG_DOC_LENGTH, 32'd0);
    row = mk(5, 3, 2, 0, 1'b1); row.known = 1; row.score = 0; dir_tab = {dir_tab, row};
    foreach (dir_tab[i]) send_term(dir_tab[i]);
    drain();
    dir_tab.delete();

    // big collection: rare, frequent, zero-query, zero term count, multi-term document
    write_reg(CFG_DOC_COUNT, 32'hFFFF_FFFF);
    write_reg(CFG_AVG_DOC_LENGTH, 32'd25600);
    row = mk(0, 16'hFFFF, 16'hFFFF, 0, 1'b1); dir_tab = {dir_tab, row};
    row = mk(24'hFFFFFF, 3, 1, 100, 1'b1); dir_tab = {dir_tab, row};
    row = mk(24'hF00000, 3, 1, 100, 1'b1); dir_tab = {dir_tab, row};
    row = mk(10, 3, 0, 100, 1'b1); row.known = 1; row.score = 0; dir_tab = {dir_tab, row};
    row = mk(10, 0, 5, 100, 1'b1); row.known = 1; row.score = 0; dir_tab = {dir_tab, row};
    row = mk(1, 7, 2, 24'hFFFFFF, 1'b0); dir_tab = {dir_tab, row};
    row = mk(100, 2, 1, 50, 1'b0); dir_tab = {dir_tab, row};
    row = mk(9000000, 2, 1, 50, 1'b1); dir_tab = {dir_tab, row};
    foreach (dir_tab[i]) send_term(dir_tab[i]);
    drain();

    // random documents across register settings, extremes included
    n_terms = 0;
    phase = 0;
    while (n_terms < 1000) begin
      write_reg(CFG_DOC_COUNT, {8'($urandom), ($urandom_range(0, 3) == 0) ?
                24'($urandom) : N_SET[phase % 4]});
      write_reg(CFG_AVG_DOC_LENGTH, ($urandom_range(0, 3) == 0) ?
                $urandom : AVG_SET[(phase / 4) % 4]);
      for (int d = 0; d < 25; d++) begin
        int len;
        len = $urandom_range(1, 6);
        for (int t = 0; t < len; t++) send_term(rand_term(t == len - 1));
        n_terms += len;
        // hold the sender until all scores are back
        if (d == 12 && phase == 1) wait_scores();
      end
      drain();
      phase++;
    end

    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
